/* design/apq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package apq_pkg;

    localparam int VAL_W = 32;
    localparam int PRI_W = 8;
    localparam int OCC_W = 8;
    localparam int ST_W  = 2;

    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_DEQ = 1'b1;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // latch the incoming word
        logic enq_write;    // append the latched entry
        logic scan_run;     // priority scan in progress
        logic shift_run;    // gap-closing shift in progress
        logic dec_count;    // one entry removed
        logic load_result;  // move result into the output register
    } apq_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic item_err;     // incoming word overflows or underflows
        logic item_enq;     // incoming word is an enqueue
        logic scan_done;
        logic shift_done;
        logic out_free;     // output register can take a result
    } apq_sts_t;

endpackage

`default_nettype wire

/* design/array_priority_queue.sv */
// Channel  Handshake                  Word
// -------  -------------------------  --------------------------------------------------
// item     item_valid / item_ready    operation, entry_value, entry_priority
// result   result_valid/result_ready  status, removed_value, removed_priority, occupancy
//
// Enqueue: the accepted word is appended, then its result is loaded (error words skip the append).
// Dequeue of N held entries, winner at index b: a scan reads all N entries, then a shift
// moves the entries after b down by one, both through the single read port of the entry
// store (one scan read, then one shift read per cycle).
// Reset (rst_n, async) empties the queue; store contents are not cleared.
// A finished result waits in the output register; a new word is taken once
// the previous one's result has moved there.
`timescale 1ns / 1ps
`default_nettype none

module array_priority_queue
    import apq_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    item_valid,
    output logic                         item_ready,
    input  wire logic                    operation,
    input  wire logic signed [VAL_W-1:0] entry_value,
    input  wire logic        [PRI_W-1:0] entry_priority,
    output logic                         result_valid,
    input  wire logic                    result_ready,
    output logic             [ST_W-1:0]  status,
    output logic signed      [VAL_W-1:0] removed_value,
    output logic             [PRI_W-1:0] removed_priority,
    output logic             [OCC_W-1:0] occupancy
);

    apq_cmd_t cmd;
    apq_sts_t sts;

    // sequencing: idle / append / scan / shift / result handoff
    apq_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    // entry store, scan and shift pointers, output register
    apq_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .operation        (operation),
        .entry_value      (entry_value),
        .entry_priority   (entry_priority),
        .result_ready     (result_ready),
        .result_valid     (result_valid),
        .status           (status),
        .removed_value    (removed_value),
        .removed_priority (removed_priority),
        .occupancy        (occupancy),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule

`default_nettype wire

/* design/apq_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module apq_ctrl
    import apq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     item_valid,
    output logic          item_ready,
    input  wire apq_sts_t sts,
    output apq_cmd_t      cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ENQ    = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_RESULT = 5'b10000
    } apq_state_t;

    apq_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.item_err)
                        state_next = S_RESULT;
                    else if (sts.item_enq)
                        state_next = S_ENQ;
                    else
                        state_next = S_SCAN;
                end
            end
            S_ENQ:
            begin
                cmd.enq_write = 1'b1;
                state_next    = S_RESULT;
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done)
                    state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                cmd.shift_run = 1'b1;
                if (sts.shift_done)
                begin
                    cmd.dec_count = 1'b1;
                    state_next    = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* design/apq_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none

module apq_datapath
    import apq_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    operation,
    input  wire logic signed [VAL_W-1:0] entry_value,
    input  wire logic        [PRI_W-1:0] entry_priority,
    input  wire logic                    result_ready,
    output logic                         result_valid,
    output logic             [ST_W-1:0]  status,
    output logic signed      [VAL_W-1:0] removed_value,
    output logic             [PRI_W-1:0] removed_priority,
    output logic             [OCC_W-1:0] occupancy,
    input  wire apq_cmd_t                cmd,
    output apq_sts_t                     sts
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int ENT_W = PRI_W + VAL_W;

    // entry store: {priority, value}
    logic [ENT_W-1:0] mem [DEPTH];
    logic [ENT_W-1:0] rd_data_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] ra_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;
    logic             out_valid_reg;

    logic [VAL_W-1:0] op_val_reg;
    logic [PRI_W-1:0] op_pri_reg;
    logic [ST_W-1:0]  item_status_reg;
    logic [IDX_W-1:0] best_idx_reg;
    logic [VAL_W-1:0] best_val_reg;
    logic [PRI_W-1:0] best_pri_reg;

    logic [ST_W-1:0]  out_status_reg;
    logic [VAL_W-1:0] out_val_reg;
    logic [PRI_W-1:0] out_pri_reg;
    logic [CNT_W-1:0] out_cnt_reg;

    logic             full;
    logic             empty;
    logic             ra_lt;
    logic             issue;
    logic             best_upd;
    logic [IDX_W-1:0] best_sel;
    logic             scan_done;
    logic             shift_done;
    logic             we;
    logic [IDX_W-1:0] wa;
    logic [ENT_W-1:0] wd;
    logic [PRI_W-1:0] rd_pri;
    logic [VAL_W-1:0] rd_val;
    logic [OCC_W+CNT_W-1:0] occ_ext;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign ra_lt  = (ra_reg < count_reg);
    assign issue  = (cmd.scan_run || cmd.shift_run) && ra_lt;
    assign rd_pri = rd_data_reg[ENT_W-1:VAL_W];
    assign rd_val = rd_data_reg[VAL_W-1:0];

    // earliest wins on ties: replace only on strictly greater
    assign best_upd = cmd.scan_run && rd_vld_reg &&
                      ((rd_idx_reg == '0) || (rd_pri > best_pri_reg));
    assign best_sel = best_upd ? rd_idx_reg : best_idx_reg;

    assign scan_done  = cmd.scan_run && rd_vld_reg &&
                        (CNT_W'(rd_idx_reg) == count_reg - CNT_W'(1));
    assign shift_done = cmd.shift_run && !ra_lt && !rd_vld_reg;

    // shift moves entry i+1 down to i, one per cycle behind the read
    assign we = cmd.enq_write || (cmd.shift_run && rd_vld_reg);
    assign wa = cmd.enq_write ? count_reg[IDX_W-1:0] : rd_idx_reg - IDX_W'(1);
    assign wd = cmd.enq_write ? {op_pri_reg, op_val_reg} : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (issue)
            rd_data_reg <= mem[ra_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_vld_reg <= issue;
            if (cmd.enq_write)
                count_reg <= count_reg + CNT_W'(1);
            else if (cmd.dec_count)
                count_reg <= count_reg - CNT_W'(1);
            if (cmd.load_result)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_val_reg   <= entry_value;
            op_pri_reg   <= entry_priority;
            ra_reg       <= '0;
            best_idx_reg <= '0;
            best_val_reg <= '0;
            best_pri_reg <= '0;
            if (sts.item_err)
                item_status_reg <= (operation == OP_DEQ) ? ST_UNDERFLOW : ST_OVERFLOW;
            else
                item_status_reg <= ST_OK;
        end
        else if (scan_done)
        begin
            ra_reg <= CNT_W'(best_sel) + CNT_W'(1);
        end
        else if (issue)
        begin
            ra_reg <= ra_reg + CNT_W'(1);
        end

        if (issue)
            rd_idx_reg <= ra_reg[IDX_W-1:0];

        if (best_upd)
        begin
            best_idx_reg <= rd_idx_reg;
            best_val_reg <= rd_val;
            best_pri_reg <= rd_pri;
        end

        if (cmd.load_result)
        begin
            out_status_reg <= item_status_reg;
            out_val_reg    <= best_val_reg;
            out_pri_reg    <= best_pri_reg;
            out_cnt_reg    <= count_reg;
        end
    end

    assign sts.item_err   = (operation == OP_DEQ) ? empty : full;
    assign sts.item_enq   = (operation == OP_ENQ);
    assign sts.scan_done  = scan_done;
    assign sts.shift_done = shift_done;
    assign sts.out_free   = !out_valid_reg || result_ready;

    assign occ_ext = {{OCC_W{1'b0}}, out_cnt_reg};

    assign result_valid     = out_valid_reg;
    assign status           = out_status_reg;
    assign removed_value    = out_val_reg;
    assign removed_priority = out_pri_reg;
    assign occupancy        = occ_ext[OCC_W-1:0];

endmodule

`default_nettype wire

/* design/apq_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module apq_checker
    import apq_pkg::*;
#(
    parameter int DEPTH = 128
)
(
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    item_valid,
    input wire logic                    item_ready,
    input wire logic                    operation,
    input wire logic signed [VAL_W-1:0] entry_value,
    input wire logic        [PRI_W-1:0] entry_priority,
    input wire logic                    result_valid,
    input wire logic                    result_ready,
    input wire logic        [ST_W-1:0]  status,
    input wire logic signed [VAL_W-1:0] removed_value,
    input wire logic        [PRI_W-1:0] removed_priority,
    input wire logic        [OCC_W-1:0] occupancy
);

    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(DEPTH);

    // stalled result keeps its status, removed value and occupancy
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable(status) && $stable(removed_value) &&
            $stable(occupancy))
        else $error("result word changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status != ST_OK |->
            removed_value == '0 && removed_priority == '0)
        else $error("error result carries a removed entry");

    a_ovf_occ: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_OVERFLOW |-> occupancy == FULL_OCC)
        else $error("overflow without full occupancy");

    a_udf_occ: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && status == ST_UNDERFLOW |-> occupancy == '0)
        else $error("underflow with entries held");

    // no new word taken while the item channel still sits in the same accept
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("two words accepted back to back");

endmodule

bind array_priority_queue apq_checker #(.DEPTH(DEPTH)) u_apq_checker (.*);

`default_nettype wire
